// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, muted in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, muted in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/scc_pkg.sv =====
`timescale 1ns / 1ps
package scc_pkg;
	localparam int NUM_PROCS = 4;
	localparam int LINES_PER_CACHE = 64;
	localparam int TOTAL_LINES = NUM_PROCS * LINES_PER_CACHE;
	localparam int PROC_W = $clog2(NUM_PROCS);
	localparam int LINE_W = $clog2(LINES_PER_CACHE);
	localparam int IDX_W = $clog2(TOTAL_LINES);

	typedef logic [2:0] coh_t;
	localparam coh_t ST_I = 3'd0;
	localparam coh_t ST_S = 3'd1;
	localparam coh_t ST_E = 3'd2;
	localparam coh_t ST_M = 3'd3;
	localparam coh_t ST_O = 3'd4;

	typedef logic [1:0] bus_t;
	localparam bus_t BUS_NONE = 2'd0;
	localparam bus_t BUS_RD   = 2'd1;
	localparam bus_t BUS_RDX  = 2'd2;
	localparam bus_t BUS_UPGR = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_MODE   = 3'd0;
	localparam reg_idx_t REG_OFFSET = 3'd1;
	localparam reg_idx_t REG_MEMLAT = 3'd2;
	localparam reg_idx_t REG_FLSLAT = 3'd3;
	localparam reg_idx_t REG_RHLAT  = 3'd4;
	localparam reg_idx_t REG_WHLAT  = 3'd5;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] age;
		coh_t        st;
	} line_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		line_t            data;
	} ram_wr_t;

	typedef struct packed {
		coh_t st;
		logic inv;
		logic flush;
		logic mem;
	} snoop_res_t;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_UPD, S_SNOOP, S_DONE} fsm_t;

	function automatic snoop_res_t snoop_apply(logic mode, coh_t st, bus_t kind);
		snoop_res_t r;
		r = '0;
		r.st = st;
		if (!mode) begin
			if (kind == BUS_RDX || kind == BUS_UPGR) begin
				r.mem = (st == ST_M) && (kind == BUS_RDX);
				r.flush = (kind == BUS_RDX);
				r.inv = 1'b1;
				r.st = ST_I;
			end else if (kind == BUS_RD) begin
				r.flush = 1'b1;
				r.st = ST_S;
			end
		end else begin
			case (st) inside
				ST_M, ST_O: begin
					if (kind == BUS_RDX || kind == BUS_UPGR) begin
						r.flush = (kind == BUS_RDX);
						r.mem = (kind == BUS_RDX) && (st == ST_O);
						r.inv = 1'b1;
						r.st = ST_I;
					end else if (kind == BUS_RD) begin
						r.flush = 1'b1;
						r.st = ST_O;
					end
				end
				ST_E: begin
					if (kind == BUS_RDX) begin
						r.inv = 1'b1;
						r.st = ST_I;
					end else if (kind == BUS_RD) begin
						r.st = ST_S;
					end
				end
				ST_S: begin
					if (kind == BUS_RDX || kind == BUS_UPGR) begin
						r.inv = 1'b1;
						r.st = ST_I;
					end
				end
				default: r.st = st;
			endcase
		end
		return r;
	endfunction
endpackage

// ===== hdl/snooping_coherence_controller_core.sv =====
`timescale 1ns / 1ps
// Four fully associative caches of 64 lines share one line memory (tag, fill stamp,
// MESI/MOESI state) read and written one entry per cycle. An access scans its own
// cache, writes the requester line, and when a bus request goes out scans all 256
// entries for snoops before the result goes to the output register. The single
// memory read port forces these sequential scans. Input is taken only when the
// previous access is done; a result waits in the output register. No clearing
// pass after reset.
module snooping_coherence_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // proc_id[1:0], address[33:2], zero fill
	input  logic [1:0]  s_tuser,   // opcode[0], other_has_copy[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit[0], new_state[3:1], bus_request[5:4], invalidation_count[7:6],
	// flush_count[9:8], memory_transactions[12:10], writeback[13],
	// latency_cycles[29:14], zero fill
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CNT_W = scc_pkg::IDX_W + 1;

	scc_pkg::fsm_t state_q, state_d;

	logic        mode_q;
	logic [3:0]  offset_q;
	logic [15:0] memlat_q, flslat_q, rhlat_q, whlat_q;

	logic [scc_pkg::PROC_W-1:0] p_q;
	logic [31:0] tag_q;
	logic        wr_q, copy_q;
	logic [31:0] fill_q;

	logic [CNT_W-1:0]          cnt_q;
	logic                      rd_v_s1;
	logic [scc_pkg::IDX_W-1:0] idx_s1;

	logic                        hit_q, inv_found_q;
	logic [scc_pkg::LINE_W-1:0]  hit_idx_q, inv_idx_q, best_idx_q;
	scc_pkg::coh_t               hit_st_q, best_st_q;
	logic [31:0]                 hit_age_q, best_age_q;

	scc_pkg::coh_t new_st_q;
	scc_pkg::bus_t bus_q;
	logic [1:0]  inv_q, flush_q;
	logic [2:0]  mem_q;
	logic        wb_q;
	logic [15:0] lat_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	logic                      issue;
	logic [scc_pkg::IDX_W-1:0] rd_addr;
	scc_pkg::line_t            rd_data;
	scc_pkg::ram_wr_t          wr;

	logic                       look_done, snoop_done, out_free;
	logic                       match;
	logic                       snoop_hit;
	scc_pkg::snoop_res_t        sres;
	logic [scc_pkg::LINE_W-1:0] k_line;
	scc_pkg::coh_t              cur_st, upd_st;
	scc_pkg::bus_t              upd_bus;
	logic [15:0]                upd_lat;
	logic                       upd_wb;

	scc_line_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	assign cfg_ready = 1'b1;
	assign look_done = (cnt_q == CNT_W'(scc_pkg::LINES_PER_CACHE)) && !rd_v_s1;
	assign snoop_done = (cnt_q == CNT_W'(scc_pkg::TOTAL_LINES)) && !rd_v_s1;
	assign out_free = !m_tvalid_q || m_tready;
	assign match = (rd_data.st != scc_pkg::ST_I) && (rd_data.tag == tag_q);
	assign snoop_hit = rd_v_s1 && match
		&& (idx_s1[scc_pkg::IDX_W-1:scc_pkg::LINE_W] != p_q);
	assign sres = scc_pkg::snoop_apply(mode_q, rd_data.st, bus_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::S_IDLE:  if (s_tvalid) state_d = scc_pkg::S_LOOK;
			scc_pkg::S_LOOK:  if (look_done) state_d = scc_pkg::S_UPD;
			scc_pkg::S_UPD:   state_d = (upd_bus != scc_pkg::BUS_NONE) ?
				scc_pkg::S_SNOOP : scc_pkg::S_DONE;
			scc_pkg::S_SNOOP: if (snoop_done) state_d = scc_pkg::S_DONE;
			scc_pkg::S_DONE:  if (out_free) state_d = scc_pkg::S_IDLE;
			default:          state_d = scc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue = 1'b0;
		rd_addr = {p_q, cnt_q[scc_pkg::LINE_W-1:0]};
		unique case (state_q)
			scc_pkg::S_IDLE: s_tready = 1'b1;
			scc_pkg::S_LOOK: issue = cnt_q < CNT_W'(scc_pkg::LINES_PER_CACHE);
			scc_pkg::S_SNOOP: begin
				issue = cnt_q < CNT_W'(scc_pkg::TOTAL_LINES);
				rd_addr = cnt_q[scc_pkg::IDX_W-1:0];
			end
			default: issue = 1'b0;
		endcase
	end

	always_comb begin
		k_line = hit_q ? hit_idx_q : (inv_found_q ? inv_idx_q : best_idx_q);
		cur_st = hit_q ? hit_st_q : scc_pkg::ST_I;
		upd_wb = !hit_q && !inv_found_q && (best_st_q == scc_pkg::ST_M);
		upd_bus = scc_pkg::BUS_NONE;
		upd_st = cur_st;
		if (!wr_q) begin
			if (cur_st == scc_pkg::ST_I) begin
				upd_st = copy_q ? scc_pkg::ST_S : scc_pkg::ST_E;
				upd_bus = copy_q ? scc_pkg::BUS_RD : scc_pkg::BUS_NONE;
			end
		end else begin
			if (cur_st == scc_pkg::ST_I) begin
				upd_bus = scc_pkg::BUS_RDX;
			end else if (cur_st == scc_pkg::ST_S || (mode_q && cur_st == scc_pkg::ST_O)) begin
				upd_bus = scc_pkg::BUS_UPGR;
			end
			upd_st = scc_pkg::ST_M;
		end
		if (hit_q) begin
			upd_lat = wr_q ? whlat_q : rhlat_q;
		end else begin
			upd_lat = copy_q ? flslat_q : memlat_q;
		end

		wr = '0;
		if (state_q == scc_pkg::S_UPD) begin
			wr.en = 1'b1;
			wr.addr = {p_q, k_line};
			wr.data.tag = tag_q;
			wr.data.age = hit_q ? hit_age_q : fill_q;
			wr.data.st = upd_st;
		end else if (state_q == scc_pkg::S_SNOOP && snoop_hit) begin
			wr.en = 1'b1;
			wr.addr = idx_s1;
			wr.data.tag = rd_data.tag;
			wr.data.age = rd_data.age;
			wr.data.st = sres.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::S_IDLE;
			mode_q <= 1'b0;
			offset_q <= 4'd6;
			memlat_q <= 16'd100;
			flslat_q <= 16'd15;
			rhlat_q <= 16'd1;
			whlat_q <= 16'd1;
			fill_q <= '0;
			cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					scc_pkg::REG_MODE:   mode_q <= cfg_data[0];
					scc_pkg::REG_OFFSET: offset_q <= cfg_data[3:0];
					scc_pkg::REG_MEMLAT: memlat_q <= cfg_data;
					scc_pkg::REG_FLSLAT: flslat_q <= cfg_data;
					scc_pkg::REG_RHLAT:  rhlat_q <= cfg_data;
					scc_pkg::REG_WHLAT:  whlat_q <= cfg_data;
					default: ;
				endcase
			end
			rd_v_s1 <= issue;
			if ((state_q == scc_pkg::S_IDLE) || (state_q == scc_pkg::S_UPD)) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == scc_pkg::S_UPD) begin
				fill_q <= fill_q + 32'd1;
			end
			if (state_q == scc_pkg::S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (state_q == scc_pkg::S_IDLE) begin
			p_q <= s_tdata[1:0];
			tag_q <= s_tdata[33:2] >> offset_q;
			wr_q <= s_tuser[0];
			copy_q <= s_tuser[1];
			hit_q <= 1'b0;
			inv_found_q <= 1'b0;
			best_age_q <= '1;
			best_idx_q <= '0;
			best_st_q <= scc_pkg::ST_I;
		end
		if (state_q == scc_pkg::S_LOOK && rd_v_s1) begin
			if (match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_s1[scc_pkg::LINE_W-1:0];
				hit_st_q <= rd_data.st;
				hit_age_q <= rd_data.age;
			end
			if (rd_data.st == scc_pkg::ST_I && !inv_found_q) begin
				inv_found_q <= 1'b1;
				inv_idx_q <= idx_s1[scc_pkg::LINE_W-1:0];
			end
			if (rd_data.age <= best_age_q) begin
				best_age_q <= rd_data.age;
				best_idx_q <= idx_s1[scc_pkg::LINE_W-1:0];
				best_st_q <= rd_data.st;
			end
		end
		if (state_q == scc_pkg::S_UPD) begin
			new_st_q <= upd_st;
			bus_q <= upd_bus;
			lat_q <= upd_lat;
			wb_q <= upd_wb;
			inv_q <= '0;
			flush_q <= '0;
			mem_q <= (!hit_q && !copy_q) ? 3'd1 : 3'd0;
		end
		if (state_q == scc_pkg::S_SNOOP && snoop_hit) begin
			if (sres.inv && inv_q != 2'd3) inv_q <= inv_q + 2'd1;
			if (sres.flush && flush_q != 2'd3) flush_q <= flush_q + 2'd1;
			if (sres.mem && mem_q != 3'd7) mem_q <= mem_q + 3'd1;
		end
		if (state_q == scc_pkg::S_DONE && out_free) begin
			m_tdata_q <= {2'b00, lat_q, wb_q, mem_q, flush_q, inv_q, bus_q, new_st_q, hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule

// ===== hdl/scc_line_ram.sv =====
`timescale 1ns / 1ps
module scc_line_ram (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [scc_pkg::IDX_W-1:0]      rd_addr,
	output scc_pkg::line_t                 rd_data,
	input  scc_pkg::ram_wr_t               wr
);
	scc_pkg::line_t                    mem_q [scc_pkg::TOTAL_LINES];
	logic [scc_pkg::TOTAL_LINES-1:0]   written_q;
	scc_pkg::line_t                    rd_raw_q;
	logic                              rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_raw_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			rd_ok_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;
endmodule

// ===== hdl/scc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "ready right after transfer")
	`ASSERT_IMPL(a_no_bus_no_snoop, m_tvalid && m_tdata[5:4] == 2'd0, m_tdata[9:6] == 4'd0, "snoop counts without bus request")
	`ASSERT_IMPL(a_hit_no_mem, m_tvalid && m_tdata[0], m_tdata[13:10] == 4'd0, "hit with memory traffic or writeback")
endmodule

bind snooping_coherence_controller_core scc_checker u_scc_checker (.*);

// ===== sim/tb_snooping_coherence_controller_core.sv =====
`timescale 1ns / 1ps
module tb_snooping_coherence_controller_core;

	typedef struct packed {
		logic [1:0]  proc_id;
		logic [31:0] address;
		logic        opcode;
		logic        other_has_copy;
	} access_t;

	typedef struct packed {
		logic            hit;
		scc_pkg::coh_t   new_state;
		scc_pkg::bus_t   bus_request;
		logic [1:0]      invalidation_count;
		logic [1:0]      flush_count;
		logic [2:0]      memory_transactions;
		logic            writeback;
		logic [15:0]     latency_cycles;
	} outcome_t;

	typedef struct {
		access_t  acc;
		logic     known;
		outcome_t res;
	} row_t;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [31:0]   tag_mem [scc_pkg::TOTAL_LINES];
	scc_pkg::coh_t coh_mem [scc_pkg::TOTAL_LINES];
	logic [31:0]   age_mem [scc_pkg::TOTAL_LINES];
	logic [31:0] fill_count;
	logic        mode;
	logic [3:0]  offset;
	logic [15:0] mem_lat, fls_lat, rh_lat, wh_lat;

	outcome_t pending_q[$];
	int       failures;
	int       idle_cycles;
	bit       draining;

	snooping_coherence_controller_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_line(int base, logic [31:0] tag);
		for (int j = 0; j < scc_pkg::LINES_PER_CACHE; j++)
			if (coh_mem[base + j] != scc_pkg::ST_I && tag_mem[base + j] == tag)
				return j;
		return -1;
	endfunction

	function automatic outcome_t predict_access(access_t a);
		outcome_t      r;
		int            base, f, k, vic, q, ln;
		logic [31:0]   tag, best;
		logic          wr, cp;
		scc_pkg::coh_t st;
		scc_pkg::bus_t bus;
		int            inv, fl, mem;
		r = '0;
		base = a.proc_id * scc_pkg::LINES_PER_CACHE;
		wr = a.opcode;
		cp = a.other_has_copy;
		tag = a.address >> offset;
		bus = scc_pkg::BUS_NONE;
		inv = 0;
		fl = 0;
		mem = 0;
		f = find_line(base, tag);
		if (f < 0) begin
			vic = -1;
			for (int j = 0; j < scc_pkg::LINES_PER_CACHE; j++)
				if (vic < 0 && coh_mem[base + j] == scc_pkg::ST_I)
					vic = j;
			if (vic < 0) begin
				best = '1;
				vic = 0;
				for (int j = 0; j < scc_pkg::LINES_PER_CACHE; j++)
					if (age_mem[base + j] <= best) begin
						best = age_mem[base + j];
						vic = j;
					end
			end
			k = base + vic;
			r.writeback = coh_mem[k] == scc_pkg::ST_M;
			coh_mem[k] = scc_pkg::ST_I;
			tag_mem[k] = tag;
			age_mem[k] = fill_count;
			r.latency_cycles = cp ? fls_lat : mem_lat;
			if (!cp)
				mem++;
		end else begin
			k = base + f;
			r.hit = 1'b1;
			r.latency_cycles = wr ? wh_lat : rh_lat;
		end
		st = coh_mem[k];
		if (!wr) begin
			if (st == scc_pkg::ST_I) begin
				coh_mem[k] = cp ? scc_pkg::ST_S : scc_pkg::ST_E;
				if (cp)
					bus = scc_pkg::BUS_RD;
			end
		end else begin
			if (st == scc_pkg::ST_I)
				bus = scc_pkg::BUS_RDX;
			else if (st == scc_pkg::ST_S || (mode && st == scc_pkg::ST_O))
				bus = scc_pkg::BUS_UPGR;
			coh_mem[k] = scc_pkg::ST_M;
		end
		if (bus != scc_pkg::BUS_NONE)
			for (q = 0; q < scc_pkg::NUM_PROCS; q++) begin
				if (q == a.proc_id)
					continue;
				f = find_line(q * scc_pkg::LINES_PER_CACHE, tag);
				if (f < 0)
					continue;
				ln = q * scc_pkg::LINES_PER_CACHE + f;
				st = coh_mem[ln];
				if (!mode) begin
					if (bus != scc_pkg::BUS_RD) begin
						if (st == scc_pkg::ST_M && bus == scc_pkg::BUS_RDX)
							mem++;
						if (bus == scc_pkg::BUS_RDX)
							fl++;
						inv++;
						coh_mem[ln] = scc_pkg::ST_I;
					end else begin
						fl++;
						coh_mem[ln] = scc_pkg::ST_S;
					end
				end else if (st == scc_pkg::ST_M || st == scc_pkg::ST_O) begin
					if (bus != scc_pkg::BUS_RD) begin
						if (bus == scc_pkg::BUS_RDX) begin
							fl++;
							if (st == scc_pkg::ST_O)
								mem++;
						end
						inv++;
						coh_mem[ln] = scc_pkg::ST_I;
					end else begin
						fl++;
						coh_mem[ln] = scc_pkg::ST_O;
					end
				end else if (st == scc_pkg::ST_E) begin
					if (bus == scc_pkg::BUS_RDX) begin
						inv++;
						coh_mem[ln] = scc_pkg::ST_I;
					end else if (bus == scc_pkg::BUS_RD) begin
						coh_mem[ln] = scc_pkg::ST_S;
					end
				end else if (st == scc_pkg::ST_S && bus != scc_pkg::BUS_RD) begin
					inv++;
					coh_mem[ln] = scc_pkg::ST_I;
				end
			end
		fill_count++;
		r.new_state = coh_mem[k];
		r.bus_request = bus;
		r.invalidation_count = inv > 3 ? 2'd3 : 2'(inv);
		r.flush_count = fl > 3 ? 2'd3 : 2'(fl);
		r.memory_transactions = mem > 7 ? 3'd7 : 3'(mem);
		return r;
	endfunction

	task automatic write_reg(scc_pkg::reg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			scc_pkg::REG_MODE:   mode = val[0];
			scc_pkg::REG_OFFSET: offset = val[3:0];
			scc_pkg::REG_MEMLAT: mem_lat = val;
			scc_pkg::REG_FLSLAT: fls_lat = val;
			scc_pkg::REG_RHLAT:  rh_lat = val;
			default:             wh_lat = val;
		endcase
	endtask

	task automatic send_access(access_t a, logic known, outcome_t res);
		outcome_t exp_res;
		int       gap;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, a.address, a.proc_id};
		s_tuser <= {a.other_has_copy, a.opcode};
		do @(posedge clk); while (!s_tready);
		exp_res = predict_access(a);
		if (known && exp_res != res) begin
			$error("table row disagrees with prediction: table %h predicted %h", res, exp_res);
			failures++;
		end
		pending_q.push_back(exp_res);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_all(logic m, logic [3:0] o, logic [15:0] ml, logic [15:0] fl,
			logic [15:0] rl, logic [15:0] wl);
		write_reg(scc_pkg::REG_MODE, 16'(m));
		write_reg(scc_pkg::REG_OFFSET, 16'(o));
		write_reg(scc_pkg::REG_MEMLAT, ml);
		write_reg(scc_pkg::REG_FLSLAT, fl);
		write_reg(scc_pkg::REG_RHLAT, rl);
		write_reg(scc_pkg::REG_WHLAT, wl);
		cfg_valid <= 1'b0;
	endtask

	function automatic access_t rand_access(int tag_span, logic [3:0] o);
		access_t a;
		a.proc_id = 2'($urandom_range(0, scc_pkg::NUM_PROCS - 1));
		if ($urandom_range(0, 9) == 0)
			a.address = $urandom;
		else
			a.address = (32'($urandom_range(0, tag_span - 1)) << o) |
				($urandom & ((32'd1 << o) - 1));
		a.opcode = 1'($urandom);
		a.other_has_copy = 1'($urandom);
		return a;
	endfunction

	// receive side: random stall, compare each transfer with the oldest prediction
	initial begin
		outcome_t got, want;
		int       gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 9);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.hit = m_tdata[0];
			got.new_state = m_tdata[3:1];
			got.bus_request = m_tdata[5:4];
			got.invalidation_count = m_tdata[7:6];
			got.flush_count = m_tdata[9:8];
			got.memory_transactions = m_tdata[12:10];
			got.writeback = m_tdata[13];
			got.latency_cycles = m_tdata[29:14];
			if (pending_q.size() == 0) begin
				$error("unexpected result %h", got);
				failures++;
			end else begin
				want = pending_q.pop_front();
				if (got.hit != want.hit) begin
					$error("hit exp %0d got %0d", want.hit, got.hit); failures++;
				end
				if (got.new_state != want.new_state) begin
					$error("new_state exp %0d got %0d", want.new_state, got.new_state);
					failures++;
				end
				if (got.bus_request != want.bus_request) begin
					$error("bus_request exp %0d got %0d", want.bus_request, got.bus_request);
					failures++;
				end
				if (got.invalidation_count != want.invalidation_count) begin
					$error("invalidation_count exp %0d got %0d",
						want.invalidation_count, got.invalidation_count);
					failures++;
				end
				if (got.flush_count != want.flush_count) begin
					$error("flush_count exp %0d got %0d", want.flush_count, got.flush_count);
					failures++;
				end
				if (got.memory_transactions != want.memory_transactions) begin
					$error("memory_transactions exp %0d got %0d",
						want.memory_transactions, got.memory_transactions);
					failures++;
				end
				if (got.writeback != want.writeback) begin
					$error("writeback exp %0d got %0d", want.writeback, got.writeback);
					failures++;
				end
				if (got.latency_cycles != want.latency_cycles) begin
					$error("latency_cycles exp %0d got %0d",
						want.latency_cycles, got.latency_cycles);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		row_t    rows[$];
		access_t a;
		int      span;
		failures = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = scc_pkg::REG_MODE;
		cfg_data = '0;
		for (int i = 0; i < scc_pkg::TOTAL_LINES; i++) begin
			tag_mem[i] = '0;
			coh_mem[i] = scc_pkg::ST_I;
			age_mem[i] = '0;
		end
		fill_count = '0;
		mode = 1'b0;
		offset = 4'd6;
		mem_lat = 16'd100;
		fls_lat = 16'd15;
		rh_lat = 16'd1;
		wh_lat = 16'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: read miss no copy -> E, latency from REG_MEMLAT, one memory transfer
		rows.push_back('{'{2'd0, 32'h0000_0040, 1'b0, 1'b0}, 1'b1,
			'{1'b0, scc_pkg::ST_E, scc_pkg::BUS_NONE, 2'd0, 2'd0, 3'd1, 1'b0, 16'd100}});
		rows.push_back('{'{2'd0, 32'h0000_0041, 1'b0, 1'b0}, 1'b1,
			'{1'b1, scc_pkg::ST_E, scc_pkg::BUS_NONE, 2'd0, 2'd0, 3'd0, 1'b0, 16'd1}});
		rows.push_back('{'{2'd0, 32'h0000_0040, 1'b1, 1'b0}, 1'b1,
			'{1'b1, scc_pkg::ST_M, scc_pkg::BUS_NONE, 2'd0, 2'd0, 3'd0, 1'b0, 16'd1}});
		rows.push_back('{'{2'd1, 32'h0000_007F, 1'b0, 1'b1}, 1'b1,
			'{1'b0, scc_pkg::ST_S, scc_pkg::BUS_RD, 2'd0, 2'd1, 3'd0, 1'b0, 16'd15}});
		rows.push_back('{'{2'd2, 32'h0000_0040, 1'b0, 1'b1}, 1'b0, '0});
		rows.push_back('{'{2'd3, 32'h0000_0040, 1'b1, 1'b1}, 1'b0, '0});
		rows.push_back('{'{2'd3, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, '0});
		rows.push_back('{'{2'd1, 32'hFFFF_FFC0, 1'b0, 1'b1}, 1'b0, '0});
		rows.push_back('{'{2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0});
		rows.push_back('{'{2'd0, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, '0});
		foreach (rows[i])
			send_access(rows[i].acc, rows[i].known, rows[i].res);
		rows.delete();
		wait_idle();

		// MOESI: owner forms on BusRd, then upgrade; FIFO eviction with writeback
		set_all(1'b1, 4'd2, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		send_access('{2'd0, 32'h100, 1'b1, 1'b0}, 1'b0, '0);
		send_access('{2'd1, 32'h100, 1'b0, 1'b1}, 1'b0, '0);
		send_access('{2'd2, 32'h100, 1'b0, 1'b1}, 1'b0, '0);
		send_access('{2'd0, 32'h100, 1'b1, 1'b1}, 1'b0, '0);
		send_access('{2'd1, 32'h100, 1'b1, 1'b0}, 1'b0, '0);
		for (int i = 0; i < scc_pkg::LINES_PER_CACHE + 3; i++)
			send_access('{2'd3, 32'(i) << 2, 1'(i % 2), 1'b0}, 1'b0, '0);
		wait_idle();
		// MESI, no offset: read miss with a copy, then a write miss from another cache
		set_all(1'b0, 4'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		send_access('{2'd0, 32'h100, 1'b0, 1'b1}, 1'b0, '0);
		send_access('{2'd1, 32'h100, 1'b1, 1'b0}, 1'b0, '0);
		wait_idle();
		set_all(1'b1, 4'd15, 16'd7, 16'd3, 16'd2, 16'd5);
		send_access('{2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, '0);
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			logic [3:0] o;
			o = 4'($urandom_range(2, 10));
			set_all(1'($urandom), o, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
			span = (phase % 2) ? 8 : 90;
			for (int i = 0; i < 160; i++) begin
				a = rand_access(span, o);
				send_access(a, 1'b0, '0);
			end
			wait_idle();
		end

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
